// ===== design/vrp_pkg.sv =====
package vrp_pkg;

  localparam int NAMETABLE_BYTES_DEF = 2048;
  localparam int PATTERN_BYTES_DEF   = 8192;
  localparam int PALETTE_BYTES       = 32;
  localparam int SPRITE_BYTES        = 256;

  localparam logic [15:0] ADDR_INC_ROW  = 16'd32;
  localparam logic [15:0] ADDR_INC_BYTE = 16'd1;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_DMA    = 2'd2,
    FUNC_STATUS = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    RIDX_CTRL     = 3'd0,
    RIDX_MASK     = 3'd1,
    RIDX_STATUS   = 3'd2,
    RIDX_OAM_ADDR = 3'd3,
    RIDX_OAM_DATA = 3'd4,
    RIDX_SCROLL   = 3'd5,
    RIDX_ADDR     = 3'd6,
    RIDX_DATA     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    VR_PAT  = 2'd0,
    VR_NT   = 2'd1,
    VR_NONE = 2'd2,
    VR_PAL  = 2'd3
  } vregion_t;

  typedef enum logic [1:0] {
    MIRROR_HORZ = 2'd0,
    MIRROR_VERT = 2'd1
  } mirror_t;

  // Video-side request from the register decode to the video memories.
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } vram_req_t;

  function automatic vregion_t vid_region(input logic [15:0] a);
    vregion_t r;
    if (a[15:13] == 3'd0) begin
      r = VR_PAT;
    end else if (a[15:12] == 4'h2) begin
      r = VR_NT;
    end else if (a[15:8] < 8'h3F) begin
      r = VR_NONE;
    end else begin
      r = VR_PAL;
    end
    return r;
  endfunction

endpackage

// ===== design/video_register_port.sv =====
// Latency: a result is registered and valid the cycle after its request is accepted.
// Throughput: one request per cycle while no result waits on out_ready; OAM and video
//   memory read data is registered, and the data-port read buffer is forwarded from the
//   memory output register.
// Reset: synchronous, active low; state registers clear, then a clearing pass zeroes
//   pattern and name-table memories with in_ready low; config writes are taken as ever.
module video_register_port
  import vrp_pkg::*;
#(
  parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
  parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_address,
  input  logic [7:0]  in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_vram_address,
  output logic [14:0] out_temp_address,
  output logic [2:0]  out_fine_scroll_x,
  output logic [7:0]  out_control_value,
  output logic [7:0]  out_mask_value,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  // architectural state
  logic [1:0]  mirror_r;
  logic [7:0]  ctrl_r,   ctrl_nxt;
  logic [7:0]  mask_r,   mask_nxt;
  logic [2:0]  status_r, status_nxt;   // vblank, sprite-zero hit, overflow
  logic [15:0] cur_r,    cur_nxt;
  logic [14:0] tmp_r,    tmp_nxt;
  logic [2:0]  fx_r,     fx_nxt;
  logic        tog_r,    tog_nxt;
  logic [7:0]  rbuf_r,   rbuf_nxt;
  logic        rb_pend_r, rb_pend_nxt; // buffer value sits in the video memory output reg
  logic [7:0]  oamp_r,   oamp_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  rd_r,     rd_nxt;
  logic        oam_sel_r, oam_sel_nxt;

  logic        acc;
  logic        clr_busy;
  func_t       func;
  reg_idx_t    ridx;
  vregion_t    cur_region;
  logic [15:0] addr_inc;
  logic [7:0]  rb_eff;
  logic [7:0]  vram_rdata;
  logic [7:0]  pal_rdata;
  logic [7:0]  oam_rdata;
  vram_req_t   vreq;
  logic        oam_wr_en;
  logic [7:0]  oam_wr_addr;
  logic        oam_rd_en;

  assign in_ready = !clr_busy && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign func     = func_t'(in_func);
  assign ridx     = reg_idx_t'(in_address[2:0]);

  assign cur_region = vid_region(cur_r);
  assign addr_inc   = ctrl_r[2] ? ADDR_INC_ROW : ADDR_INC_BYTE;
  assign rb_eff     = rb_pend_r ? vram_rdata : rbuf_r;

  always_comb begin
    ctrl_nxt    = ctrl_r;
    mask_nxt    = mask_r;
    status_nxt  = status_r;
    cur_nxt     = cur_r;
    tmp_nxt     = tmp_r;
    fx_nxt      = fx_r;
    tog_nxt     = tog_r;
    rbuf_nxt    = rb_eff;
    rb_pend_nxt = rb_pend_r;
    oamp_nxt    = oamp_r;
    rd_nxt      = 8'h00;
    oam_sel_nxt = 1'b0;
    vreq.rd_en  = 1'b0;
    vreq.wr_en  = 1'b0;
    vreq.addr   = cur_r;
    vreq.wdata  = in_write_data;
    oam_wr_en   = 1'b0;
    oam_wr_addr = oamp_r;
    oam_rd_en   = 1'b0;

    unique case (func)
      FUNC_READ: begin
        unique case (ridx)
          RIDX_STATUS: begin
            rd_nxt        = {status_r, rb_eff[4:0]};
            status_nxt[2] = 1'b0;
            tog_nxt       = 1'b0;
          end
          RIDX_OAM_DATA: begin
            oam_rd_en   = acc;
            oam_sel_nxt = 1'b1;
          end
          RIDX_DATA: begin
            cur_nxt = cur_r + addr_inc;
            unique case (cur_region)
              VR_PAL: begin
                // palette bypasses the buffer but still refills it
                rd_nxt      = pal_rdata;
                rbuf_nxt    = pal_rdata;
                rb_pend_nxt = 1'b0;
              end
              VR_NONE: begin
                rd_nxt      = rb_eff;
                rbuf_nxt    = 8'h00;
                rb_pend_nxt = 1'b0;
              end
              default: begin
                rd_nxt      = rb_eff;
                vreq.rd_en  = acc;
                rb_pend_nxt = 1'b1;
              end
            endcase
          end
          default: begin
          end
        endcase
      end
      FUNC_WRITE: begin
        unique case (ridx)
          RIDX_CTRL: begin
            ctrl_nxt       = in_write_data;
            tmp_nxt[11:10] = in_write_data[1:0];
          end
          RIDX_MASK: begin
            mask_nxt = in_write_data;
          end
          RIDX_OAM_ADDR: begin
            oamp_nxt = in_write_data;
          end
          RIDX_OAM_DATA: begin
            oam_wr_en = acc;
            oamp_nxt  = oamp_r + 8'd1;
          end
          RIDX_SCROLL: begin
            if (!tog_r) begin
              fx_nxt       = in_write_data[2:0];
              tmp_nxt[4:0] = in_write_data[7:3];
              tog_nxt      = 1'b1;
            end else begin
              tmp_nxt[14:12] = in_write_data[2:0];
              tmp_nxt[9:5]   = in_write_data[7:3];
              tog_nxt        = 1'b0;
            end
          end
          RIDX_ADDR: begin
            if (!tog_r) begin
              tmp_nxt[14]   = 1'b0;
              tmp_nxt[13:8] = in_write_data[5:0];
              tog_nxt       = 1'b1;
            end else begin
              tmp_nxt[7:0] = in_write_data;
              cur_nxt      = {1'b0, tmp_r[14:8], in_write_data};
              tog_nxt      = 1'b0;
            end
          end
          RIDX_DATA: begin
            vreq.wr_en = acc;
            cur_nxt    = cur_r + addr_inc;
          end
          default: begin
            // status register is read-only
          end
        endcase
      end
      FUNC_DMA: begin
        oam_wr_en   = acc;
        oam_wr_addr = in_address;
      end
      default: begin
        status_nxt = in_write_data[7:5];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 2'd0;
    end else if (cfg_wr_en) begin
      mirror_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      mask_r      <= '0;
      status_r    <= '0;
      cur_r       <= '0;
      tmp_r       <= '0;
      fx_r        <= '0;
      tog_r       <= 1'b0;
      rbuf_r      <= '0;
      rb_pend_r   <= 1'b0;
      oamp_r      <= '0;
      out_valid_r <= 1'b0;
      oam_sel_r   <= 1'b0;
    end else begin
      if (acc) begin
        ctrl_r    <= ctrl_nxt;
        mask_r    <= mask_nxt;
        status_r  <= status_nxt;
        cur_r     <= cur_nxt;
        tmp_r     <= tmp_nxt;
        fx_r      <= fx_nxt;
        tog_r     <= tog_nxt;
        rbuf_r    <= rbuf_nxt;
        rb_pend_r <= rb_pend_nxt;
        oamp_r    <= oamp_nxt;
        oam_sel_r <= oam_sel_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= rd_nxt;
    end
  end

  vrp_vram #(
    .NAMETABLE_BYTES (NAMETABLE_BYTES),
    .PATTERN_BYTES   (PATTERN_BYTES)
  ) u_vram (
    .clk         (clk),
    .rst_n       (rst_n),
    .mirror_mode (mirror_r),
    .req         (vreq),
    .rd_data     (vram_rdata),
    .pal_data    (pal_rdata),
    .clr_busy    (clr_busy)
  );

  vrp_oam u_oam (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oam_wr_en),
    .wr_addr (oam_wr_addr),
    .wr_data (in_write_data),
    .rd_en   (oam_rd_en),
    .rd_addr (oamp_r),
    .rd_data (oam_rdata)
  );

  // OAM data reads come straight from the sprite memory output register
  assign out_valid         = out_valid_r;
  assign out_read_data     = oam_sel_r ? oam_rdata : rd_r;
  assign out_vram_address  = cur_r;
  assign out_temp_address  = tmp_r;
  assign out_fine_scroll_x = fx_r;
  assign out_control_value = ctrl_r;
  assign out_mask_value    = mask_r;

  // no request is taken during the memory clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("request accepted while memories are clearing");

  a_ctrl_write: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && func == FUNC_WRITE && ridx == RIDX_CTRL)
      |=> (out_control_value == $past(in_write_data)))
    else $error("control write not reflected in result");

  a_status_read: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && func == FUNC_READ && ridx == RIDX_STATUS) |=> (!status_r[2] && !tog_r))
    else $error("status read did not clear vblank and toggle");

  a_dma_keeps_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && func == FUNC_DMA) |=> (oamp_r == $past(oamp_r)))
    else $error("DMA byte moved the OAM pointer");

  a_pal_read_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && func == FUNC_READ && ridx == RIDX_DATA && cur_region == VR_PAL)
      |=> (out_read_data == rbuf_r && !rb_pend_r))
    else $error("palette read did not bypass the read buffer");

endmodule

// ===== design/vrp_oam.sv =====
module vrp_oam
  import vrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);

  logic [7:0]              mem [SPRITE_BYTES];
  logic [SPRITE_BYTES-1:0] valid_r;
  logic [7:0]              q_r;
  logic                    q_valid_r;

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r       <= mem[rd_addr];
      q_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = q_valid_r ? q_r : 8'h00;

endmodule

// ===== design/vrp_vram.sv =====
module vrp_vram
  import vrp_pkg::*;
#(
  parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
  parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [1:0] mirror_mode,
  input  vram_req_t req,
  output logic [7:0] rd_data,
  output logic [7:0] pal_data,
  output logic       clr_busy
);

  localparam int NT_AW   = $clog2(NAMETABLE_BYTES);
  localparam int PAT_AW  = $clog2(PATTERN_BYTES);
  localparam int CLR_LEN = (PATTERN_BYTES > NAMETABLE_BYTES) ? PATTERN_BYTES : NAMETABLE_BYTES;
  localparam int CW      = $clog2(CLR_LEN);

  logic [7:0] pat_mem [PATTERN_BYTES];
  logic [7:0] nt_mem  [NAMETABLE_BYTES];
  logic [7:0] pal_r   [PALETTE_BYTES];

  logic [7:0]    pat_q_r;
  logic [7:0]    nt_q_r;
  logic          src_nt_r;
  logic          clr_r;
  logic [CW-1:0] clr_cnt_r;

  vregion_t      region;
  logic [10:0]   nt_raw;
  logic [NT_AW-1:0]  nt_idx;
  logic [13:0]   pat_a14;
  logic [13:0]   pat_sub;
  logic [PAT_AW-1:0] pat_idx;
  logic [4:0]    pal_rd_idx;
  logic [4:0]    pal_wr_idx;
  logic          clr_nt;
  logic          clr_pat;

  assign region = vid_region(req.addr);

  always_comb begin
    unique case (mirror_mode)
      MIRROR_HORZ: nt_raw = {req.addr[11], req.addr[9:0]};
      MIRROR_VERT: nt_raw = {req.addr[10], req.addr[9:0]};
      default:     nt_raw = 11'd0;
    endcase
  end
  assign nt_idx = NT_AW'(nt_raw);

  // user keeps pattern depth >= half the 8 KB window: one conditional subtract
  assign pat_a14 = {1'b0, req.addr[12:0]};
  assign pat_sub = pat_a14 - 14'(PATTERN_BYTES);
  assign pat_idx = (pat_a14 >= 14'(PATTERN_BYTES)) ? PAT_AW'(pat_sub) : PAT_AW'(pat_a14);

  assign pal_rd_idx = (req.addr[1:0] == 2'b00) ? 5'd0 : req.addr[4:0];
  assign pal_wr_idx = (req.addr[4] && req.addr[1:0] == 2'b00) ?
                      {1'b0, req.addr[3:0]} : req.addr[4:0];

  assign clr_nt  = clr_r && ({1'b0, clr_cnt_r} < (CW+1)'(NAMETABLE_BYTES));
  assign clr_pat = clr_r && ({1'b0, clr_cnt_r} < (CW+1)'(PATTERN_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CW'(CLR_LEN - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_pat) begin
      pat_mem[clr_cnt_r[PAT_AW-1:0]] <= 8'h00;
    end else if (req.wr_en && region == VR_PAT) begin
      pat_mem[pat_idx] <= req.wdata;
    end
    if (req.rd_en) begin
      pat_q_r <= pat_mem[pat_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_nt) begin
      nt_mem[clr_cnt_r[NT_AW-1:0]] <= 8'h00;
    end else if (req.wr_en && region == VR_NT) begin
      nt_mem[nt_idx] <= req.wdata;
    end
    if (req.rd_en) begin
      nt_q_r   <= nt_mem[nt_idx];
      src_nt_r <= (region == VR_NT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_BYTES; i++) begin
        pal_r[i] <= 8'h00;
      end
    end else if (req.wr_en && region == VR_PAL) begin
      pal_r[pal_wr_idx] <= req.wdata;
    end
  end

  assign pal_data = pal_r[pal_rd_idx];
  assign rd_data  = src_nt_r ? nt_q_r : pat_q_r;
  assign clr_busy = clr_r;

endmodule

// ===== test/vrp_check_pkg.sv =====
package vrp_check_pkg;
  import vrp_pkg::*;

  localparam logic [15:0] NT_BASE       = 16'h2000;
  localparam logic [15:0] UNMAPPED_BASE = 16'h3000;
  localparam logic [15:0] PAL_BASE      = 16'h3F00;

  // mirror codes beyond the two named in the design package: all name-table
  // accesses collapse onto byte 0
  localparam logic [1:0] MIRROR_ONE_A = 2'd2;
  localparam logic [1:0] MIRROR_ONE_B = 2'd3;

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [7:0]  read_data;
    logic [15:0] vram_address;
    logic [14:0] temp_address;
    logic [2:0]  fine_scroll_x;
    logic [7:0]  control_value;
    logic [7:0]  mask_value;
  } port_result_t;

  class video_port_scoreboard;
    bit [1:0]     mirror;
    bit [7:0]     ctrl;
    bit [7:0]     mask;
    bit [2:0]     flags;
    bit [15:0]    vaddr;
    bit [14:0]    taddr;
    bit [2:0]     fine_x;
    bit           toggle;
    bit [7:0]     rbuf;
    bit [7:0]     oam_ptr;
    bit [7:0]     oam [SPRITE_BYTES];
    bit [7:0]     nt  [NAMETABLE_BYTES_DEF];
    bit [7:0]     pal [PALETTE_BYTES];
    bit [7:0]     pat [PATTERN_BYTES_DEF];
    port_result_t expected_q [$];
    int           mismatches;
    int           checked;

    function void set_mirror(logic [1:0] m);
      mirror = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit [10:0] nt_slot(bit [15:0] a);
      bit [10:0] s;
      if (mirror == MIRROR_HORZ) begin
        s = {a[11], a[9:0]};
      end else if (mirror == MIRROR_VERT) begin
        s = {a[10], a[9:0]};
      end else begin
        s = '0;
      end
      return s;
    endfunction

    function bit [7:0] vid_fetch(bit [15:0] a);
      bit [4:0] p;
      bit [7:0] d;
      p = a[4:0];
      if (a < NT_BASE) begin
        d = pat[a[12:0]];
      end else if (a < UNMAPPED_BASE) begin
        d = nt[nt_slot(a)];
      end else if (a < PAL_BASE) begin
        d = '0;
      end else begin
        if (p[1:0] == 2'b00) p = '0;  // backdrop entries all read entry 0
        d = pal[p];
      end
      return d;
    endfunction

    function void vid_store(bit [15:0] a, bit [7:0] d);
      bit [4:0] p;
      p = a[4:0];
      if (a < NT_BASE) begin
        pat[a[12:0]] = d;
      end else if (a < UNMAPPED_BASE) begin
        nt[nt_slot(a)] = d;
      end else if (a >= PAL_BASE) begin
        if (p[1:0] == 2'b00) p[4] = 1'b0;  // sprite backdrop mirrors
        pal[p] = d;
      end
    endfunction

    function void step_addr();
      vaddr = vaddr + (ctrl[2] ? ADDR_INC_ROW : ADDR_INC_BYTE);
    endfunction

    function void note_request(func_t f, logic [7:0] a, logic [7:0] d);
      bit [7:0] rd;
      reg_idx_t r;
      rd = '0;
      r  = reg_idx_t'(a[2:0]);
      case (f)
        FUNC_READ: begin
          case (r)
            RIDX_STATUS: begin
              rd       = {flags, rbuf[4:0]};
              flags[2] = 1'b0;
              toggle   = 1'b0;
            end
            RIDX_OAM_DATA: rd = oam[oam_ptr];
            RIDX_DATA: begin
              rd   = rbuf;
              rbuf = vid_fetch(vaddr);
              if (vaddr >= PAL_BASE) rd = rbuf;
              step_addr();
            end
            default: ;
          endcase
        end
        FUNC_WRITE: begin
          case (r)
            RIDX_CTRL: begin
              ctrl          = d;
              taddr[11:10]  = d[1:0];
            end
            RIDX_MASK:     mask = d;
            RIDX_OAM_ADDR: oam_ptr = d;
            RIDX_OAM_DATA: begin
              oam[oam_ptr] = d;
              oam_ptr      = oam_ptr + 8'd1;
            end
            RIDX_SCROLL: begin
              if (!toggle) begin
                fine_x     = d[2:0];
                taddr[4:0] = d[7:3];
              end else begin
                taddr[14:12] = d[2:0];
                taddr[9:5]   = d[7:3];
              end
              toggle = ~toggle;
            end
            RIDX_ADDR: begin
              if (!toggle) begin
                taddr[14:8] = {1'b0, d[5:0]};
              end else begin
                taddr[7:0] = d;
                vaddr      = {1'b0, taddr};
              end
              toggle = ~toggle;
            end
            RIDX_DATA: begin
              vid_store(vaddr, d);
              step_addr();
            end
            default: ;
          endcase
        end
        FUNC_DMA:    oam[a] = d;
        FUNC_STATUS: flags = d[7:5];
        default: ;
      endcase
      expected_q.push_back('{rd, vaddr, taddr, fine_x, ctrl, mask});
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on result %0d, %s: expected %h, got %h", checked, field, want, got);
    endfunction

    function void check_result(port_result_t got);
      port_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with no request outstanding (read_data %h)", got.read_data);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.read_data !== want.read_data)
        flag("read_data", 16'(want.read_data), 16'(got.read_data));
      if (got.vram_address !== want.vram_address)
        flag("vram_address", want.vram_address, got.vram_address);
      if (got.temp_address !== want.temp_address)
        flag("temp_address", 16'(want.temp_address), 16'(got.temp_address));
      if (got.fine_scroll_x !== want.fine_scroll_x)
        flag("fine_scroll_x", 16'(want.fine_scroll_x), 16'(got.fine_scroll_x));
      if (got.control_value !== want.control_value)
        flag("control_value", 16'(want.control_value), 16'(got.control_value));
      if (got.mask_value !== want.mask_value)
        flag("mask_value", 16'(want.mask_value), 16'(got.mask_value));
    endfunction
  endclass

endpackage

// ===== test/tb_video_register_port.sv =====
module tb_video_register_port;
  import vrp_pkg::*;
  import vrp_check_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;    // long receiver hold-off for back-pressure
  localparam int DRAIN_CYCLES   = 8;      // margin on top of the result latency
  // Longest correct quiet stretch is the memory clearing pass after reset;
  // the limit sits well above it.
  localparam int WATCHDOG_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [7:0]  in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic [15:0] out_vram_address;
  logic [14:0] out_temp_address;
  logic [2:0]  out_fine_scroll_x;
  logic [7:0]  out_control_value;
  logic [7:0]  out_mask_value;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;

  video_port_scoreboard sb = new;
  port_result_t         seen_result;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_req      = 0;   // bumped by the stimulus to ask the receiver for a hold-off
  int requests_sent = 0;
  int bursts        = 0;
  int quiet_cycles  = 0;
  int full_stalls   = 0;

  video_register_port u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_vram_address  (out_vram_address),
    .out_temp_address  (out_temp_address),
    .out_fine_scroll_x (out_fine_scroll_x),
    .out_control_value (out_control_value),
    .out_mask_value    (out_mask_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Monitors: everything is sampled at the rising edge, before any of the
  // nonblocking updates of that edge land, so DUT and testbench see the same
  // handshake. The result is checked before the request of the same edge is
  // noted, so a result that shows up in the same cycle as its request is caught.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result = '{out_read_data, out_vram_address, out_temp_address,
                      out_fine_scroll_x, out_control_value, out_mask_value};
      sb.check_result(seen_result);
    end
    if (rst_n && in_valid && in_ready)
      sb.note_request(func_t'(in_func), in_address, in_write_data);
    // input blocked while the held result waits on a stalled receiver
    if (rst_n && in_valid && !in_ready && out_valid && !out_ready)
      full_stalls++;
  end

  // Watchdog: any cycle with no request and no result accepted counts toward
  // the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready at the current idle rate; on a hold request it keeps
  // ready low for HOLD_CYCLES, counted here, while the sender keeps pushing.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int seen_hold;
    seen_hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_hold) begin
        seen_hold = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All are entered and left in the time step of a rising edge.
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Register select with random upper address bits (the block only decodes the
  // low three).
  function automatic logic [7:0] reg_addr(reg_idx_t r);
    logic [4:0] hi;
    hi = 5'($urandom);
    return {hi, r};
  endfunction

  // One request: optional idle gap, then hold valid and payload until taken.
  task automatic send_request(func_t f, logic [7:0] a, logic [7:0] d);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_address    <= a;
    in_write_data <= d;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Stop sending and wait until every result has been taken. The extra edge
  // lets the monitor note a request accepted on the edge we were called at.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mirror mode changes only with the block idle.
  task automatic write_mirror(logic [1:0] m);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mirror(m);
  endtask

  // Two writes to the address register: high byte then low byte.
  task automatic set_vaddr(logic [7:0] hi, logic [7:0] lo);
    send_request(FUNC_WRITE, reg_addr(RIDX_ADDR), hi);
    send_request(FUNC_WRITE, reg_addr(RIDX_ADDR), lo);
  endtask

  // Well-formed data-port burst: reset the toggle with a status read, point
  // the address at one region, then either write a run and read it back
  // (one extra read flushes the buffer) or do a random read/write mix.
  task automatic data_burst();
    logic [7:0] hi;
    logic [7:0] lo;
    int         n;
    case ($urandom_range(0, 4))
      0:       hi = 8'($urandom_range(8'h00, 8'h1F));   // pattern store
      1:       hi = 8'($urandom_range(8'h20, 8'h2F));   // name tables
      2:       hi = 8'($urandom_range(8'h30, 8'h3E));   // unmapped hole
      3:       hi = 8'h3F;                              // palette
      default: hi = rand_byte();
    endcase
    lo = rand_byte();
    n  = $urandom_range(1, 6);
    bursts++;
    send_request(FUNC_READ, reg_addr(RIDX_STATUS), rand_byte());
    set_vaddr(hi, lo);
    if ($urandom_range(0, 1)) begin
      repeat (n) send_request(FUNC_WRITE, reg_addr(RIDX_DATA), rand_byte());
      set_vaddr(hi, lo);
      repeat (n + 1) send_request(FUNC_READ, reg_addr(RIDX_DATA), rand_byte());
    end else begin
      repeat (n) send_request(func_t'($urandom_range(0, 1)), reg_addr(RIDX_DATA),
                              rand_byte());
    end
  endtask

  // Random phase: mostly well-formed sequences with random content, the rest
  // broken sequences and pure noise.
  task automatic run_phase(int n);
    int         stop;
    logic [7:0] ptr;
    logic [7:0] off;
    stop = requests_sent + n;
    while (requests_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2: data_burst();
        3: send_request(FUNC_WRITE, reg_addr($urandom_range(0, 1) ? RIDX_CTRL : RIDX_MASK),
                        rand_byte());
        4: begin
          // scroll pair; sometimes without the toggle reset, so the pair splits
          if ($urandom_range(0, 3) != 0)
            send_request(FUNC_READ, reg_addr(RIDX_STATUS), rand_byte());
          send_request(FUNC_WRITE, reg_addr(RIDX_SCROLL), rand_byte());
          send_request(FUNC_WRITE, reg_addr(RIDX_SCROLL), rand_byte());
          send_request(FUNC_READ, reg_addr(reg_idx_t'($urandom_range(0, 7))),
                       rand_byte());
        end
        5: begin
          // OAM port: random run at a pointer, then read back the start byte
          ptr = rand_byte();
          send_request(FUNC_WRITE, reg_addr(RIDX_OAM_ADDR), ptr);
          repeat ($urandom_range(1, 4))
            send_request(func_t'($urandom_range(0, 1)), reg_addr(RIDX_OAM_DATA),
                         rand_byte());
          send_request(FUNC_WRITE, reg_addr(RIDX_OAM_ADDR), ptr);
          send_request(FUNC_READ, reg_addr(RIDX_OAM_DATA), rand_byte());
        end
        6: begin
          // DMA bytes, then read the last one through the OAM port
          off = rand_byte();
          repeat ($urandom_range(1, 4)) begin
            off = rand_byte();
            send_request(FUNC_DMA, off, rand_byte());
          end
          send_request(FUNC_WRITE, reg_addr(RIDX_OAM_ADDR), off);
          send_request(FUNC_READ, reg_addr(RIDX_OAM_DATA), rand_byte());
        end
        7: begin
          send_request(FUNC_STATUS, rand_byte(), rand_byte());
          send_request(FUNC_READ, reg_addr(RIDX_STATUS), rand_byte());
        end
        default: send_request(func_t'($urandom_range(0, 3)), rand_byte(), rand_byte());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FUNC_READ;
    in_address    = '0;
    in_write_data = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under vertical mirroring. The block is still clearing
    // its memories here, so the first request waits on in_ready.
    write_mirror(MIRROR_VERT);
    send_request(FUNC_STATUS, 8'hFF, 8'hFF);                     // all flags set
    send_request(FUNC_READ,   8'hFA, 8'h00);                     // status read clears vblank
    send_request(FUNC_WRITE,  reg_addr(RIDX_STATUS), 8'hFF);     // ignored
    send_request(FUNC_READ,   8'hF8, 8'hFF);                     // write-only register
    send_request(FUNC_WRITE,  reg_addr(RIDX_CTRL), 8'hFF);       // +32 stepping
    send_request(FUNC_WRITE,  reg_addr(RIDX_MASK), 8'hFF);
    send_request(FUNC_WRITE,  reg_addr(RIDX_SCROLL), 8'hFF);
    send_request(FUNC_WRITE,  reg_addr(RIDX_SCROLL), 8'h00);
    set_vaddr(8'hFF, 8'h1C);                                     // high byte trimmed: 3F1C
    send_request(FUNC_WRITE,  reg_addr(RIDX_DATA), 8'hA5);       // lands on palette 0C
    send_request(FUNC_READ,   reg_addr(RIDX_DATA), 8'h00);       // 3F3C reads entry 0
    send_request(FUNC_WRITE,  reg_addr(RIDX_CTRL), 8'h00);
    set_vaddr(8'h30, 8'h00);                                     // unmapped hole
    send_request(FUNC_WRITE,  reg_addr(RIDX_DATA), 8'h33);
    send_request(FUNC_READ,   reg_addr(RIDX_DATA), 8'hCC);
    set_vaddr(8'h2F, 8'hFF);                                     // top of name tables
    send_request(FUNC_WRITE,  reg_addr(RIDX_DATA), 8'hC3);
    send_request(FUNC_WRITE,  reg_addr(RIDX_OAM_ADDR), 8'hFF);
    send_request(FUNC_WRITE,  reg_addr(RIDX_OAM_DATA), 8'h81);   // pointer wraps to 0
    send_request(FUNC_READ,   reg_addr(RIDX_OAM_DATA), 8'h00);
    send_request(FUNC_DMA,    8'hFF, 8'h7E);
    send_request(FUNC_DMA,    8'h00, 8'h00);

    // Random phases: receiver idles more, then the sender, then neither.
    write_mirror(MIRROR_HORZ);
    src_idle_pct  = 34;
    sink_idle_pct = 51;
    run_phase(400);

    write_mirror(MIRROR_ONE_A);
    src_idle_pct  = 51;
    sink_idle_pct = 34;
    run_phase(400);

    // No idling; the receiver holds off for a long stretch at the start so the
    // result path fills and the input stalls.
    write_mirror(MIRROR_ONE_B);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req <= hold_req + 1;
    run_phase(400);

    write_mirror(MIRROR_VERT);
    run_phase(380);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d data-port bursts), %0d results checked, mirror 0-3",
             requests_sent, bursts, sb.checked);
    $display("input stalled behind a full result path for %0d cycles, %0d mismatches",
             full_stalls, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
